// ===== rtl/core/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants of the clock presence detector
// Holds register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package ccd_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;
   localparam int LevelWidth    = 12;
   localparam int RunWidth      = 8;
   localparam int TimeWidth     = 32;
   localparam int AdjustWidth   = 16;
   localparam int WindowWidth   = 24;
   localparam int CountWidth    = 32;

   localparam logic [LevelWidth-1:0]  LevelLowReset       = 12'd1000;
   localparam logic [LevelWidth-1:0]  LevelHighReset      = 12'd3500;
   localparam logic [RunWidth-1:0]    RunLimitReset       = 8'd20;
   localparam logic [TimeWidth-1:0]   HoldTimeReset       = 32'd1000;
   localparam logic [AdjustWidth-1:0] IntervalAdjustReset = 16'd0;
   localparam logic [WindowWidth-1:0] ValidWindowReset    = 24'd96000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LEVEL_LOW       = 3'd0,
      CSR_LEVEL_HIGH      = 3'd1,
      CSR_RUN_LIMIT       = 3'd2,
      CSR_HOLD_TIME       = 3'd3,
      CSR_INTERVAL_ADJUST = 3'd4,
      CSR_VALID_WINDOW    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LevelWidth-1:0]  level_low;
      logic [LevelWidth-1:0]  level_high;
      logic [RunWidth-1:0]    run_limit;
      logic [TimeWidth-1:0]   hold_time;
      logic [AdjustWidth-1:0] interval_adjust;
      logic [WindowWidth-1:0] valid_window;
   } ccd_cfg_type;

endpackage

// ===== rtl/core/clock_presence_detector_top.sv =====
// ----------------------------------------------------------------------------
// clock_presence_detector_top: external clock presence detector
// A request is taken into the request register and moved on into the result
// register, which drives the result ports, once that register frees up.
// Throughput: one request per cycle while rsp_stall is low, set by the
// single-pass update of detector state between request and result registers.
// Reset: synchronous; clears all detector state and loads register defaults.
// ----------------------------------------------------------------------------
module clock_presence_detector_top
   import ccd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [LevelWidth-1:0]    req_cv_level,
   input  logic                     req_clock_level,
   input  logic [TimeWidth-1:0]     req_time_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_clock_ok,
   output logic [CountWidth-1:0]    rsp_edge_interval,
   output logic                     rsp_edge_seen,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   ccd_cfg_type cfg;

   logic                  in_valid_ff, in_valid_in;
   logic [LevelWidth-1:0] in_cv_ff;
   logic                  in_pin_ff;
   logic [TimeWidth-1:0]  in_time_ff;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_ok_ff;
   logic [CountWidth-1:0] out_interval_ff;
   logic                  out_edge_ff;

   logic                  accept;
   logic                  advance;
   logic                  core_ok;
   logic [CountWidth-1:0] core_interval;
   logic                  core_edge;

   ccd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ccd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .advance       (advance),
      .cv_level      (in_cv_ff),
      .clock_level   (in_pin_ff),
      .time_ms       (in_time_ff),
      .clock_ok      (core_ok),
      .edge_interval (core_interval),
      .edge_seen     (core_edge)
   );

   // move a request into the result register when that register frees up
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cv_ff   <= req_cv_level;
         in_pin_ff  <= req_clock_level;
         in_time_ff <= req_time_ms;
      end
      if (advance) begin
         out_ok_ff       <= core_ok;
         out_interval_ff <= core_interval;
         out_edge_ff     <= core_edge;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_clock_ok      = out_ok_ff;
   assign rsp_edge_interval = out_interval_ff;
   assign rsp_edge_seen     = out_edge_ff;

endmodule

// ===== rtl/core/ccd_csr.sv =====
// ----------------------------------------------------------------------------
// ccd_csr: configuration registers
// Six writable registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ccd_csr
   import ccd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output ccd_cfg_type              cfg
);

   ccd_cfg_type cfg_ff;
   ccd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEVEL_LOW:       cfg_in.level_low       = csr_data[LevelWidth-1:0];
            CSR_LEVEL_HIGH:      cfg_in.level_high      = csr_data[LevelWidth-1:0];
            CSR_RUN_LIMIT:       cfg_in.run_limit       = csr_data[RunWidth-1:0];
            CSR_HOLD_TIME:       cfg_in.hold_time       = csr_data[TimeWidth-1:0];
            CSR_INTERVAL_ADJUST: cfg_in.interval_adjust = csr_data[AdjustWidth-1:0];
            CSR_VALID_WINDOW:    cfg_in.valid_window    = csr_data[WindowWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_low       <= LevelLowReset;
         cfg_ff.level_high      <= LevelHighReset;
         cfg_ff.run_limit       <= RunLimitReset;
         cfg_ff.hold_time       <= HoldTimeReset;
         cfg_ff.interval_adjust <= IntervalAdjustReset;
         cfg_ff.valid_window    <= ValidWindowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/ccd_core.sv =====
// ----------------------------------------------------------------------------
// ccd_core: detector state and per-sample update
// Tracks the non-clock run, the stamp time and the edge counters, and
// computes one result from the registered request.
// ----------------------------------------------------------------------------
module ccd_core
   import ccd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ccd_cfg_type            cfg,
   input  logic                   advance,
   input  logic [LevelWidth-1:0]  cv_level,
   input  logic                   clock_level,
   input  logic [TimeWidth-1:0]   time_ms,
   output logic                   clock_ok,
   output logic [CountWidth-1:0]  edge_interval,
   output logic                   edge_seen
);

   logic [RunWidth-1:0]   run_count_ff, run_count_in;
   logic [TimeWidth-1:0]  stamp_time_ff, stamp_time_in;
   logic                  pin_was_high_ff, pin_was_high_in;
   logic [CountWidth-1:0] sample_count_ff, sample_count_in;
   logic [CountWidth-1:0] last_edge_ff, last_edge_in;
   logic [CountWidth-1:0] interval_ff, interval_in;

   logic                  in_band;
   logic [RunWidth:0]     run_next;
   logic                  blocked;
   logic                  rise;
   logic [CountWidth-1:0] since_edge;

   always_comb begin
      in_band  = (cv_level > cfg.level_low) && (cv_level < cfg.level_high);
      run_next = {1'b0, run_count_ff} + {{RunWidth{1'b0}}, 1'b1};

      run_count_in  = '0;
      stamp_time_in = stamp_time_ff;
      if (in_band) begin
         // restart the run and stamp once the limit is passed
         if (run_next > {1'b0, cfg.run_limit}) begin
            stamp_time_in = time_ms;
         end else begin
            run_count_in = run_next[RunWidth-1:0];
         end
      end

      blocked = (time_ms - stamp_time_in) < cfg.hold_time;

      rise            = clock_level && !pin_was_high_ff;
      pin_was_high_in = clock_level;
      interval_in     = interval_ff;
      last_edge_in    = last_edge_ff;
      if (rise) begin
         interval_in  = sample_count_ff - last_edge_ff
                        - {{(CountWidth-AdjustWidth){1'b0}}, cfg.interval_adjust};
         last_edge_in = sample_count_ff;
      end

      since_edge = sample_count_ff - last_edge_in;
      clock_ok   = !blocked
                   && (since_edge < {{(CountWidth-WindowWidth){1'b0}}, cfg.valid_window});

      sample_count_in = sample_count_ff + {{(CountWidth-1){1'b0}}, 1'b1};
      edge_interval   = interval_in;
      edge_seen       = rise;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff    <= '0;
         stamp_time_ff   <= '0;
         pin_was_high_ff <= 1'b0;
         sample_count_ff <= '0;
         last_edge_ff    <= '0;
         interval_ff     <= '0;
      end else if (advance) begin
         run_count_ff    <= run_count_in;
         stamp_time_ff   <= stamp_time_in;
         pin_was_high_ff <= pin_was_high_in;
         sample_count_ff <= sample_count_in;
         last_edge_ff    <= last_edge_in;
         interval_ff     <= interval_in;
      end
   end

endmodule
